@@ rtl/core/iqg_pkg.sv @@
// Shared constants, types and saturation helpers for the image quad generator.
`timescale 1ns / 1ps
package iqg_pkg;

   localparam int MAX_QUADS = 64;
   localparam int NUM_W     = $clog2(MAX_QUADS + 1);

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_TILE  = 2'd1;
   localparam logic [1:0] MODE_NINE  = 2'd2;

   localparam logic [2:0] REG_GRID_LEFT   = 3'd0;
   localparam logic [2:0] REG_GRID_RIGHT  = 3'd1;
   localparam logic [2:0] REG_GRID_TOP    = 3'd2;
   localparam logic [2:0] REG_GRID_BOTTOM = 3'd3;
   localparam logic [2:0] REG_SCALE       = 3'd4;

   localparam int DIV_NUM_W = 33;
   localparam int CORNER_W  = 21;
   localparam int POS_W     = 24;

   typedef enum logic [2:0] {
      OP_MUL  = 3'b001,
      OP_DIV  = 3'b010,
      OP_LERP = 3'b100
   } op_type;

   typedef struct packed {
      op_type      kind;
      logic [15:0] mul_a;
      logic [15:0] mul_b;
      logic [15:0] num;
      logic [15:0] den;
      logic [15:0] start;
      logic        neg;
   } step_type;

   function automatic logic [15:0] sat_s16(input logic signed [POS_W-1:0] v);
      logic [15:0] r;
      if (v > 24'sd32767) r = 16'h7fff;
      else if (v < -24'sd32768) r = 16'h8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic [15:0] sat_u16(input logic signed [POS_W-1:0] v);
      logic [15:0] r;
      if (v > 24'sd65535) r = 16'hffff;
      else if (v < 24'sd0) r = 16'h0000;
      else r = v[15:0];
      return r;
   endfunction

endpackage

@@ rtl/core/image_quad_generator.sv @@
// Top level: request sequencer, shared multiplier/divider and quad emitter.
//
//  port group | dir | beat contents
//  req_*      | in  | one widget request
//  rsp_*      | out | one textured quad, tlast on the final quad
//  csr_*      | in  | grid edges and corner scale registers
//
// Plain requests emit in the cycle after accept. Tile: two divisions, one multiply
// and two UV interpolations, then one quad per cycle while rsp_tready is high.
// Nine-slice: four multiplies and four interpolations, then a walk over the grid
// cells with a quad per non-empty cell. The shared divider yields 33 quotient bits
// and sets the setup time. Synchronous reset restores CSR, state and divider control;
// rsp stalls hold the emitter, req_tready is low until the last quad is taken.
`timescale 1ns / 1ps
module image_quad_generator
   import iqg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // ctrl_width, ctrl_height, tex_width, tex_height, uv_left, uv_top,
   // uv_right, uv_bottom, color
   input  logic [159:0] req_tdata,
   // mode, flip
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // quad_x, quad_y, quad_w, quad_h, tex_u0, tex_v0, tex_u1, tex_v1,
   // quad_color, quad_number, zero pad
   output logic [167:0] rsp_tdata,
   // truncated
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ISSUE = 5'b00010,
      S_MUL   = 5'b00100,
      S_DIV   = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] grid_left_ff, grid_right_ff, grid_top_ff, grid_bottom_ff, scale_ff;
   logic [2:0]  csr_idx;

   logic [15:0] cw_ff, ch_ff, tw_ff, th_ff, ul_ff, vt_ff, ur_ff, vb_ff;
   logic [31:0] color_ff;
   logic [1:0]  mode_ff, flip_ff;
   logic [3:0]  k_ff;
   logic [31:0] prod_ff;

   logic [15:0] cols_ff, rows_ff, wrem_ff, hrem_ff, ulast_ff, vlast_ff;
   logic        trunc_ff;
   logic [CORNER_W-1:0] wl_ff, wr_ff, ht_ff, hb_ff;
   logic [15:0] gu1_ff, gu2_ff, gv1_ff, gv2_ff;

   logic [15:0] col_ff, row_ff, x_ff, y_ff;
   logic [NUM_W-1:0] n_ff;

   step_type    step;
   logic [3:0]  nsteps;
   logic [15:0] rmin, bmin;
   logic [1:0]  eff_mode;
   logic        has_tex;

   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_dividend, div_quot;
   logic [15:0]          div_rem;

   logic                 wb_en;
   logic [CORNER_W-1:0]  mul_round;
   logic [15:0]          lerp_val;
   logic [33:0]          lerp_sum;

   logic                 accept, out_fire, emit_last, emit_valid;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_left_ff   <= '0;
         grid_right_ff  <= '0;
         grid_top_ff    <= '0;
         grid_bottom_ff <= '0;
         scale_ff       <= 16'd4096;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            REG_GRID_LEFT:   grid_left_ff   <= csr_pwdata[15:0];
            REG_GRID_RIGHT:  grid_right_ff  <= csr_pwdata[15:0];
            REG_GRID_TOP:    grid_top_ff    <= csr_pwdata[15:0];
            REG_GRID_BOTTOM: grid_bottom_ff <= csr_pwdata[15:0];
            REG_SCALE:       scale_ff       <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_GRID_LEFT:   csr_prdata = {16'd0, grid_left_ff};
         REG_GRID_RIGHT:  csr_prdata = {16'd0, grid_right_ff};
         REG_GRID_TOP:    csr_prdata = {16'd0, grid_top_ff};
         REG_GRID_BOTTOM: csr_prdata = {16'd0, grid_bottom_ff};
         REG_SCALE:       csr_prdata = {16'd0, scale_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // request capture
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign has_tex    = (req_tdata[47:32] != 16'd0) && (req_tdata[63:48] != 16'd0);

   always_comb begin
      if (req_tuser[1:0] == MODE_TILE && has_tex) eff_mode = MODE_TILE;
      else if (req_tuser[1:0] == MODE_NINE && has_tex) eff_mode = MODE_NINE;
      else eff_mode = MODE_PLAIN;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cw_ff    <= req_tdata[15:0];
         ch_ff    <= req_tdata[31:16];
         tw_ff    <= req_tdata[47:32];
         th_ff    <= req_tdata[63:48];
         ul_ff    <= req_tdata[79:64];
         vt_ff    <= req_tdata[95:80];
         ur_ff    <= req_tdata[111:96];
         vb_ff    <= req_tdata[127:112];
         color_ff <= req_tdata[159:128];
         mode_ff  <= eff_mode;
         flip_ff  <= req_tuser[3:2];
      end
   end

   // step decode
   assign rmin = (grid_right_ff < tw_ff) ? grid_right_ff : tw_ff;
   assign bmin = (grid_bottom_ff < th_ff) ? grid_bottom_ff : th_ff;

   always_comb begin
      step.kind  = OP_MUL;
      step.mul_a = '0;
      step.mul_b = '0;
      step.num   = '0;
      step.den   = tw_ff;
      step.start = ul_ff;
      step.neg   = ur_ff < ul_ff;
      step.mul_a = step.neg ? (ul_ff - ur_ff) : (ur_ff - ul_ff);
      nsteps     = 4'd0;
      case (mode_ff)
         MODE_TILE: begin
            nsteps = 4'd5;
            case (k_ff)
               4'd0: begin
                  step.kind = OP_DIV;
                  step.num  = cw_ff;
               end
               4'd1: begin
                  step.kind = OP_DIV;
                  step.num  = ch_ff;
                  step.den  = th_ff;
               end
               4'd2: begin
                  step.mul_a = cols_ff;
                  step.mul_b = rows_ff;
               end
               4'd3: begin
                  step.kind  = OP_LERP;
                  step.mul_b = wrem_ff;
               end
               default: begin
                  step.kind  = OP_LERP;
                  step.den   = th_ff;
                  step.start = vt_ff;
                  step.neg   = vb_ff < vt_ff;
                  step.mul_a = step.neg ? (vt_ff - vb_ff) : (vb_ff - vt_ff);
                  step.mul_b = hrem_ff;
               end
            endcase
         end
         MODE_NINE: begin
            nsteps = 4'd8;
            case (k_ff)
               4'd0: begin
                  step.mul_a = grid_left_ff;
                  step.mul_b = scale_ff;
               end
               4'd1: begin
                  step.mul_a = tw_ff - rmin;
                  step.mul_b = scale_ff;
               end
               4'd2: begin
                  step.mul_a = grid_top_ff;
                  step.mul_b = scale_ff;
               end
               4'd3: begin
                  step.mul_a = th_ff - bmin;
                  step.mul_b = scale_ff;
               end
               4'd4: begin
                  step.kind  = OP_LERP;
                  step.mul_b = grid_left_ff;
               end
               4'd5: begin
                  step.kind  = OP_LERP;
                  step.mul_b = rmin;
               end
               default: begin
                  step.kind  = OP_LERP;
                  step.den   = th_ff;
                  step.start = vt_ff;
                  step.neg   = vb_ff < vt_ff;
                  step.mul_a = step.neg ? (vt_ff - vb_ff) : (vb_ff - vt_ff);
                  step.mul_b = (k_ff == 4'd6) ? grid_top_ff : bmin;
               end
            endcase
         end
         default: nsteps = 4'd0;
      endcase
   end

   // shared arithmetic
   always_ff @(posedge clock) begin
      if (state_ff == S_ISSUE) prod_ff <= step.mul_a * step.mul_b;
   end

   assign div_start    = ((state_ff == S_ISSUE) && (k_ff != nsteps) && (step.kind == OP_DIV))
                      || ((state_ff == S_MUL) && (step.kind == OP_LERP));
   assign div_dividend = (step.kind == OP_DIV) ? {17'd0, step.num}
                       : ({1'b0, prod_ff} + {18'd0, step.den[15:1]});

   iqg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (step.den),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      logic [32:0] rounded;
      rounded   = {1'b0, prod_ff} + 33'd2048;
      mul_round = rounded[32:12];
      lerp_sum  = {18'd0, step.start} + {1'b0, div_quot};
      if (step.neg) begin
         lerp_val = ({1'b0, div_quot} > {18'd0, step.start}) ? 16'd0
                  : (step.start - div_quot[15:0]);
      end else begin
         lerp_val = (lerp_sum > 34'd65535) ? 16'hffff : lerp_sum[15:0];
      end
   end

   assign wb_en = ((state_ff == S_MUL) && (step.kind == OP_MUL))
               || ((state_ff == S_DIV) && div_done);

   always_ff @(posedge clock) begin
      if (wb_en) begin
         case (mode_ff)
            MODE_TILE: begin
               case (k_ff)
                  4'd0: begin
                     cols_ff <= div_quot[15:0] + {15'd0, div_rem != 16'd0};
                     wrem_ff <= div_rem;
                  end
                  4'd1: begin
                     rows_ff <= div_quot[15:0] + {15'd0, div_rem != 16'd0};
                     hrem_ff <= div_rem;
                  end
                  4'd2: trunc_ff <= prod_ff > 32'(MAX_QUADS);
                  4'd3: ulast_ff <= lerp_val;
                  default: vlast_ff <= lerp_val;
               endcase
            end
            default: begin
               case (k_ff)
                  4'd0: wl_ff  <= mul_round;
                  4'd1: wr_ff  <= mul_round;
                  4'd2: ht_ff  <= mul_round;
                  4'd3: hb_ff  <= mul_round;
                  4'd4: gu1_ff <= lerp_val;
                  4'd5: gu2_ff <= lerp_val;
                  4'd6: gv1_ff <= lerp_val;
                  default: gv2_ff <= lerp_val;
               endcase
            end
         endcase
      end
   end

   // nine-slice geometry
   logic signed [POS_W-1:0] px [4];
   logic signed [POS_W-1:0] py [4];
   logic signed [POS_W-1:0] cell_w [3];
   logic signed [POS_W-1:0] cell_h [3];
   logic [15:0] gu [4];
   logic [15:0] gv [4];
   logic [8:0]  mask, later;
   logic [3:0]  idx;

   always_comb begin
      px[0] = '0;
      px[1] = {3'd0, wl_ff};
      px[2] = $signed({8'd0, cw_ff}) - $signed({3'd0, wr_ff});
      px[3] = {8'd0, cw_ff};
      py[0] = '0;
      py[1] = {3'd0, ht_ff};
      py[2] = $signed({8'd0, ch_ff}) - $signed({3'd0, hb_ff});
      py[3] = {8'd0, ch_ff};
      for (int i = 0; i < 3; i++) begin
         cell_w[i] = px[i+1] - px[i];
         cell_h[i] = py[i+1] - py[i];
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mask[r*3+c] = (cell_w[c] > 0) && (cell_h[r] > 0);
         end
      end
      gu[0] = ul_ff;
      gu[1] = gu1_ff;
      gu[2] = gu2_ff;
      gu[3] = ur_ff;
      gv[0] = vt_ff;
      gv[1] = gv1_ff;
      gv[2] = gv2_ff;
      gv[3] = vb_ff;
      idx   = {row_ff[1:0], 1'b0} + {2'd0, row_ff[1:0]} + {2'd0, col_ff[1:0]};
      later = mask >> (idx + 4'd1);
   end

   // quad output
   logic signed [POS_W-1:0] o_x, o_y, o_w, o_h;
   logic [15:0] o_u0, o_v0, o_u1, o_v1, f_u0, f_v0, f_u1, f_v1;
   logic        tile_last_col, tile_last_row, o_trunc;

   always_comb begin
      tile_last_col = (col_ff == cols_ff - 16'd1);
      tile_last_row = (row_ff == rows_ff - 16'd1);
      o_trunc       = 1'b0;
      case (mode_ff)
         MODE_TILE: begin
            o_x  = {8'd0, x_ff};
            o_y  = {8'd0, y_ff};
            o_w  = {8'd0, (tile_last_col && wrem_ff != 16'd0) ? wrem_ff : tw_ff};
            o_h  = {8'd0, (tile_last_row && hrem_ff != 16'd0) ? hrem_ff : th_ff};
            o_u0 = ul_ff;
            o_v0 = vt_ff;
            o_u1 = (tile_last_col && wrem_ff != 16'd0) ? ulast_ff : ur_ff;
            o_v1 = (tile_last_row && hrem_ff != 16'd0) ? vlast_ff : vb_ff;
            o_trunc    = trunc_ff;
            emit_valid = 1'b1;
            emit_last  = (n_ff == NUM_W'(MAX_QUADS - 1)) || (tile_last_col && tile_last_row);
         end
         MODE_NINE: begin
            o_x  = px[col_ff[1:0]];
            o_y  = py[row_ff[1:0]];
            o_w  = cell_w[col_ff[1:0]];
            o_h  = cell_h[row_ff[1:0]];
            o_u0 = gu[col_ff[1:0]];
            o_v0 = gv[row_ff[1:0]];
            o_u1 = gu[col_ff[1:0] + 2'd1];
            o_v1 = gv[row_ff[1:0] + 2'd1];
            emit_valid = mask[idx];
            emit_last  = mask[idx] && (later == 9'd0);
         end
         default: begin
            o_x  = '0;
            o_y  = '0;
            o_w  = {8'd0, cw_ff};
            o_h  = {8'd0, ch_ff};
            o_u0 = ul_ff;
            o_v0 = vt_ff;
            o_u1 = ur_ff;
            o_v1 = vb_ff;
            emit_valid = 1'b1;
            emit_last  = 1'b1;
         end
      endcase
      f_u0 = flip_ff[0] ? o_u1 : o_u0;
      f_u1 = flip_ff[0] ? o_u0 : o_u1;
      f_v0 = flip_ff[1] ? o_v1 : o_v0;
      f_v1 = flip_ff[1] ? o_v0 : o_v1;
   end

   assign rsp_tvalid = (state_ff == S_EMIT) && emit_valid;
   assign rsp_tlast  = emit_last;
   assign rsp_tuser  = o_trunc;
   assign rsp_tdata  = {2'd0, n_ff[5:0], color_ff, f_v1, f_u1, f_v0, f_u0,
                        sat_u16(o_h), sat_u16(o_w), sat_s16(o_y), sat_s16(o_x)};
   assign out_fire   = rsp_tvalid && rsp_tready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = (eff_mode == MODE_PLAIN) ? S_EMIT : S_ISSUE;
         end
         S_ISSUE: begin
            if (k_ff == nsteps) begin
               if (mode_ff == MODE_TILE)
                  state_in = (cols_ff == 16'd0 || rows_ff == 16'd0) ? S_IDLE : S_EMIT;
               else
                  state_in = (mask == 9'd0) ? S_IDLE : S_EMIT;
            end else begin
               state_in = (step.kind == OP_DIV) ? S_DIV : S_MUL;
            end
         end
         S_MUL: state_in = (step.kind == OP_LERP) ? S_DIV : S_ISSUE;
         S_DIV: begin
            if (div_done) state_in = S_ISSUE;
         end
         S_EMIT: begin
            if (out_fire && emit_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) k_ff <= '0;
         else if (wb_en) k_ff <= k_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= '0;
         row_ff <= '0;
         x_ff   <= '0;
         y_ff   <= '0;
         n_ff   <= '0;
      end else if (state_ff == S_EMIT && (out_fire || !emit_valid)) begin
         if (out_fire) n_ff <= n_ff + 1'b1;
         if (mode_ff == MODE_TILE) begin
            if (tile_last_col) begin
               col_ff <= '0;
               x_ff   <= '0;
               row_ff <= row_ff + 16'd1;
               y_ff   <= y_ff + th_ff;
            end else begin
               col_ff <= col_ff + 16'd1;
               x_ff   <= x_ff + tw_ff;
            end
         end else begin
            if (col_ff == 16'd2) begin
               col_ff <= '0;
               row_ff <= row_ff + 16'd1;
            end else begin
               col_ff <= col_ff + 16'd1;
            end
         end
      end
   end

endmodule

@@ rtl/core/iqg_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module iqg_div
   import iqg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [15:0]          divisor,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quot,
   output logic [15:0]          rem
);

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 run_ff, done_ff;
   logic [16:0]          shifted, diff;
   logic                 qbit;

   always_comb begin
      shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      qbit    = shifted >= {1'b0, den_ff};
      rem_in  = qbit ? diff[15:0] : shifted[15:0];
      num_in  = {num_ff[DIV_NUM_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (run_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;

endmodule

@@ tb/image_quad_generator_test.sv @@
// Self-checking testbench for the image quad generator: stream stimulus, quad prediction, checks.
`timescale 1ns / 1ps
module image_quad_generator_test
   import iqg_pkg::*;
();

   typedef struct packed {
      logic [15:0] cw, ch, tw, th, ul, vt, ur, vb;
      logic [1:0]  mode, flip;
      logic [31:0] color;
   } request_type;

   typedef struct packed {
      logic [15:0] x, y, w, h, u0, v0, u1, v1;
      logic [31:0] color;
      logic [5:0]  num;
      logic        last, trunc;
   } quad_type;

   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 1500;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [159:0] req_tdata = '0;
   logic [3:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [167:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   image_quad_generator u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   request_type pending_requests[$];
   quad_type    expected_quads[$];
   logic [15:0] g_left, g_right, g_top, g_bottom, g_scale;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_cycles = 0;
   bit hold_start = 0;
   bit hold_armed = 0;
   bit req_taken = 0;
   int failures = 0;
   int idle_count = 0;

   function automatic logic [15:0] clamp_s(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic logic [15:0] clamp_u(longint v);
      if (v > 65535) return 16'hffff;
      if (v < 0) return 16'h0000;
      return v[15:0];
   endfunction

   function automatic logic [15:0] interp_uv(longint s, longint e, longint num, longint den);
      longint d, mag, q;
      d = e - s;
      mag = (d < 0 ? -d : d) * num;
      q = (mag + den / 2) / den;
      return clamp_u(d < 0 ? s - q : s + q);
   endfunction

   task automatic add_request(input request_type r);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic push_quad(input request_type r, input longint x, y, w, h,
                            input logic [15:0] u0, v0, u1, v1,
                            input logic trunc, inout int n);
      quad_type q;
      logic [15:0] t;
      if (r.flip[0]) begin t = u0; u0 = u1; u1 = t; end
      if (r.flip[1]) begin t = v0; v0 = v1; v1 = t; end
      q.x = clamp_s(x); q.y = clamp_s(y); q.w = clamp_u(w); q.h = clamp_u(h);
      q.u0 = u0; q.v0 = v0; q.u1 = u1; q.v1 = v1;
      q.color = r.color; q.num = n[5:0]; q.last = 0; q.trunc = trunc;
      expected_quads.insert(expected_quads.size(), q);
      n++;
   endtask

   task automatic predict_quads(input request_type r);
      longint cols, rows, x, y, ww, hh, rmin, bmin, wl, wr, ht, hb, w, h;
      longint px[4], py[4];
      logic [15:0] gu[4], gv[4], u1, v1;
      logic trunc;
      int n;
      bit has_tex;
      n = 0;
      has_tex = r.tw != 0 && r.th != 0;
      if (r.mode == MODE_TILE && has_tex) begin
         cols = (longint'(r.cw) + r.tw - 1) / r.tw;
         rows = (longint'(r.ch) + r.th - 1) / r.th;
         trunc = rows * cols > MAX_QUADS;
         for (longint rr = 0; rr < rows && n < MAX_QUADS; rr++) begin
            y = rr * r.th;
            hh = (r.ch - y < r.th) ? r.ch - y : r.th;
            v1 = interp_uv(r.vt, r.vb, hh, r.th);
            for (longint cc = 0; cc < cols && n < MAX_QUADS; cc++) begin
               x = cc * r.tw;
               ww = (r.cw - x < r.tw) ? r.cw - x : r.tw;
               u1 = interp_uv(r.ul, r.ur, ww, r.tw);
               push_quad(r, x, y, ww, hh, r.ul, r.vt, u1, v1, trunc, n);
            end
         end
      end else if (r.mode == MODE_NINE && has_tex) begin
         rmin = g_right < r.tw ? g_right : r.tw;
         bmin = g_bottom < r.th ? g_bottom : r.th;
         wl = (longint'(g_left) * g_scale + 2048) >>> 12;
         wr = ((r.tw - rmin) * g_scale + 2048) >>> 12;
         ht = (longint'(g_top) * g_scale + 2048) >>> 12;
         hb = ((r.th - bmin) * g_scale + 2048) >>> 12;
         px[0] = 0; px[1] = wl; px[2] = longint'(r.cw) - wr; px[3] = r.cw;
         py[0] = 0; py[1] = ht; py[2] = longint'(r.ch) - hb; py[3] = r.ch;
         gu[0] = r.ul; gu[1] = interp_uv(r.ul, r.ur, g_left, r.tw);
         gu[2] = interp_uv(r.ul, r.ur, rmin, r.tw); gu[3] = r.ur;
         gv[0] = r.vt; gv[1] = interp_uv(r.vt, r.vb, g_top, r.th);
         gv[2] = interp_uv(r.vt, r.vb, bmin, r.th); gv[3] = r.vb;
         for (int rr = 0; rr < 3; rr++)
            for (int cc = 0; cc < 3; cc++) begin
               w = px[cc + 1] - px[cc];
               h = py[rr + 1] - py[rr];
               if (w > 0 && h > 0)
                  push_quad(r, px[cc], py[rr], w, h, gu[cc], gv[rr], gu[cc + 1],
                            gv[rr + 1], 1'b0, n);
            end
      end else begin
         push_quad(r, 0, 0, r.cw, r.ch, r.ul, r.vt, r.ur, r.vb, 1'b0, n);
      end
      if (n > 0) expected_quads[$].last = 1;
   endtask

   // input beat taken at the last rising edge
   always @(posedge clock) begin
      if (reset) req_taken <= 0;
      else req_taken <= req_tvalid && req_tready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken && pending_requests.size() > 0)
            void'(pending_requests.pop_front());
         if (req_tvalid && !req_taken) begin
         end else if (pending_requests.size() > 0 &&
                      ($urandom_range(99, 0) >= send_idle_pct)) begin
            request_type r;
            r = pending_requests[0];
            req_tvalid <= 1;
            req_tdata <= {r.color, r.vb, r.ur, r.vt, r.ul, r.th, r.tw, r.ch, r.cw};
            req_tuser <= {r.flip, r.mode};
         end else begin
            req_tvalid <= 0;
         end
         if (hold_start && !hold_armed) begin
            hold_armed <= 1;
            hold_cycles <= HOLD_CYCLES;
            rsp_tready <= 0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            request_type r;
            r.cw = req_tdata[15:0]; r.ch = req_tdata[31:16];
            r.tw = req_tdata[47:32]; r.th = req_tdata[63:48];
            r.ul = req_tdata[79:64]; r.vt = req_tdata[95:80];
            r.ur = req_tdata[111:96]; r.vb = req_tdata[127:112];
            r.color = req_tdata[159:128];
            r.mode = req_tuser[1:0]; r.flip = req_tuser[3:2];
            predict_quads(r);
         end
         if (rsp_tvalid && rsp_tready) begin
            quad_type e;
            if (expected_quads.size() == 0) begin
               $error("unexpected quad beat %h", rsp_tdata);
               failures++;
            end else begin
               e = expected_quads.pop_front();
               if (rsp_tdata[15:0] !== e.x) begin
                  $error("quad_x exp %h got %h", e.x, rsp_tdata[15:0]); failures++; end
               if (rsp_tdata[31:16] !== e.y) begin
                  $error("quad_y exp %h got %h", e.y, rsp_tdata[31:16]); failures++; end
               if (rsp_tdata[47:32] !== e.w) begin
                  $error("quad_w exp %h got %h", e.w, rsp_tdata[47:32]); failures++; end
               if (rsp_tdata[63:48] !== e.h) begin
                  $error("quad_h exp %h got %h", e.h, rsp_tdata[63:48]); failures++; end
               if (rsp_tdata[79:64] !== e.u0) begin
                  $error("tex_u0 exp %h got %h", e.u0, rsp_tdata[79:64]); failures++; end
               if (rsp_tdata[95:80] !== e.v0) begin
                  $error("tex_v0 exp %h got %h", e.v0, rsp_tdata[95:80]); failures++; end
               if (rsp_tdata[111:96] !== e.u1) begin
                  $error("tex_u1 exp %h got %h", e.u1, rsp_tdata[111:96]); failures++; end
               if (rsp_tdata[127:112] !== e.v1) begin
                  $error("tex_v1 exp %h got %h", e.v1, rsp_tdata[127:112]); failures++; end
               if (rsp_tdata[159:128] !== e.color) begin
                  $error("quad_color exp %h got %h", e.color, rsp_tdata[159:128]);
                  failures++; end
               if (rsp_tdata[165:160] !== e.num) begin
                  $error("quad_number exp %0d got %0d", e.num, rsp_tdata[165:160]);
                  failures++; end
               if (rsp_tlast !== e.last) begin
                  $error("last_quad exp %b got %b", e.last, rsp_tlast); failures++; end
               if (rsp_tuser[0] !== e.trunc) begin
                  $error("truncated exp %b got %b", e.trunc, rsp_tuser[0]); failures++; end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("image_quad_generator_test failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= {16'h0, val};
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         REG_GRID_LEFT:   g_left = val;
         REG_GRID_RIGHT:  g_right = val;
         REG_GRID_TOP:    g_top = val;
         REG_GRID_BOTTOM: g_bottom = val;
         default:         g_scale = val;
      endcase
   endtask

   task automatic drain_quads();
      while (pending_requests.size() > 0 || req_tvalid || expected_quads.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic request_type random_request(input int small_pct);
      request_type r;
      r.tw = 16'($urandom_range(65535, 0));
      r.th = 16'($urandom_range(65535, 0));
      r.cw = 16'($urandom_range(65535, 0));
      r.ch = 16'($urandom_range(65535, 0));
      r.mode = 2'($urandom_range(3, 0));
      if (r.mode == MODE_TILE && $urandom_range(99, 0) < 85) begin
         r.tw = 16'($urandom_range(400, 1));
         r.th = 16'($urandom_range(400, 1));
         r.cw = 16'($urandom_range(r.tw * 9, 0));
         r.ch = 16'($urandom_range(r.th * 9, 0));
      end else if ($urandom_range(99, 0) < small_pct) begin
         r.tw = 16'($urandom_range(1024, 1));
         r.th = 16'($urandom_range(1024, 1));
         r.cw = 16'($urandom_range(2048, 0));
         r.ch = 16'($urandom_range(2048, 0));
      end
      r.ul = 16'($urandom); r.vt = 16'($urandom); r.ur = 16'($urandom); r.vb = 16'($urandom);
      r.flip = 2'($urandom_range(3, 0));
      r.color = $urandom;
      return r;
   endfunction

   function automatic request_type make_req(input logic [15:0] cw, ch, tw, th,
                                            input logic [1:0] mode, flip);
      request_type r;
      r.cw = cw; r.ch = ch; r.tw = tw; r.th = th;
      r.ul = 16'h1000; r.vt = 16'h2000; r.ur = 16'hf000; r.vb = 16'he000;
      r.mode = mode; r.flip = flip; r.color = $urandom;
      return r;
   endfunction

   initial begin
      g_left = '0; g_right = '0; g_top = '0; g_bottom = '0; g_scale = 16'd4096;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      csr_write(REG_GRID_LEFT, 16'h0040);
      csr_write(REG_GRID_RIGHT, 16'h00c0);
      csr_write(REG_GRID_TOP, 16'h0030);
      csr_write(REG_GRID_BOTTOM, 16'h00d0);
      csr_write(REG_SCALE, 16'h2000);

      // directed
      add_request(make_req(16'h0, 16'h0, 16'h100, 16'h100, MODE_PLAIN, 2'd0));
      add_request(make_req(16'hffff, 16'hffff, 16'hffff, 16'hffff, MODE_PLAIN, 2'd3));
      add_request(make_req(16'h400, 16'h300, 16'h100, 16'h100, MODE_TILE, 2'd1));
      add_request(make_req(16'h450, 16'h310, 16'h100, 16'h100, MODE_TILE, 2'd2));
      add_request(make_req(16'hffff, 16'hffff, 16'h10, 16'h10, MODE_TILE, 2'd0));
      add_request(make_req(16'h0, 16'h100, 16'h100, 16'h100, MODE_TILE, 2'd0));
      add_request(make_req(16'h400, 16'h400, 16'h0, 16'h100, MODE_TILE, 2'd0));
      add_request(make_req(16'h400, 16'h400, 16'h100, 16'h100, MODE_NINE, 2'd3));
      add_request(make_req(16'h80, 16'h80, 16'h100, 16'h100, MODE_NINE, 2'd1));
      add_request(make_req(16'h0, 16'h0, 16'h100, 16'h100, MODE_NINE, 2'd0));
      add_request(make_req(16'h400, 16'h400, 16'h100, 16'h0, MODE_NINE, 2'd2));
      add_request(make_req(16'h200, 16'h200, 16'h100, 16'h100, MODE_SPARE, 2'd1));
      add_request(make_req(16'hffff, 16'h8000, 16'h40, 16'h60, MODE_NINE, 2'd0));
      begin
         request_type r;
         r = make_req(16'h300, 16'h300, 16'h100, 16'h100, MODE_NINE, 2'd0);
         r.ul = 16'hffff; r.ur = 16'h0; r.vt = 16'h0; r.vb = 16'hffff;
         r.color = 32'hffffffff;
         add_request(r);
      end
      drain_quads();

      // oversized borders, zero scale
      csr_write(REG_GRID_LEFT, 16'hffff);
      csr_write(REG_GRID_RIGHT, 16'hffff);
      csr_write(REG_GRID_TOP, 16'hffff);
      csr_write(REG_GRID_BOTTOM, 16'h0);
      csr_write(REG_SCALE, 16'h0);
      add_request(make_req(16'h400, 16'h400, 16'h100, 16'h100, MODE_NINE, 2'd0));
      add_request(make_req(16'hffff, 16'hffff, 16'h10, 16'h10, MODE_NINE, 2'd3));
      drain_quads();
      csr_write(REG_SCALE, 16'hffff);
      csr_write(REG_GRID_LEFT, 16'h0800);
      csr_write(REG_GRID_TOP, 16'h0);
      add_request(make_req(16'hffff, 16'hffff, 16'h1000, 16'h1000, MODE_NINE, 2'd0));
      add_request(make_req(16'h100, 16'h100, 16'h1000, 16'h1000, MODE_NINE, 2'd1));
      drain_quads();

      // long receiver hold while requests keep coming
      for (int i = 0; i < 6; i++)
         add_request(make_req(16'h400, 16'h300, 16'h100, 16'h100, MODE_TILE, 2'd0));
      hold_start = 1;
      drain_quads();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 6 : (phase == 1 ? 53 : 0);
         recv_idle_pct = phase == 0 ? 53 : (phase == 1 ? 6 : 0);
         csr_write(REG_GRID_LEFT, 16'($urandom_range(512, 0)));
         csr_write(REG_GRID_RIGHT, 16'($urandom_range(1024, 0)));
         csr_write(REG_GRID_TOP, 16'($urandom_range(512, 0)));
         csr_write(REG_GRID_BOTTOM, 16'($urandom_range(1024, 0)));
         csr_write(REG_SCALE, 16'($urandom_range(16384, 1)));
         for (int i = 0; i < 70; i++) begin
            add_request(random_request(80));
            if (i == 35) drain_quads();
         end
         drain_quads();
      end
      if (failures == 0)
         $display("image_quad_generator_test passed");
      else
         $display("image_quad_generator_test failed");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/iqg_pkg.sv
rtl/core/iqg_div.sv
rtl/core/image_quad_generator.sv
tb/image_quad_generator_test.sv
